>>> rtl/block_key_dense_renumber_macros.svh
// Assertion macros for the dense renumber block.
`ifndef BLOCK_KEY_DENSE_RENUMBER_MACROS_SVH
`define BLOCK_KEY_DENSE_RENUMBER_MACROS_SVH
// assert that an implication holds on every edge outside reset
`define BKDR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bkdr check failed");
// assert that an implication holds in the cycle after the antecedent
`define BKDR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bkdr check failed");
`endif

>>> rtl/bkdr_pkg.sv
// Package for the dense renumber block: sizes and shared types.
`default_nettype none
package bkdr_pkg;
	localparam int PAIR_SLOTS = 256;
	localparam int FILE_SLOTS = 64;
	localparam int PCW = $clog2(PAIR_SLOTS + 1);
	localparam int FCW = $clog2(FILE_SLOTS + 1);
	localparam int PIW = $clog2(PAIR_SLOTS);

	typedef struct packed {
		logic [31:0] fid;
		logic [31:0] blk;
	} key_t;

	typedef struct packed {
		logic        hit;
		logic [PIW-1:0] idx;
	} match_t;
endpackage
`default_nettype wire

>>> rtl/bkdr_pair_cell.sv
// One pair cell: holds a key, compares it, passes the first match down the chain.
`default_nettype none
module bkdr_pair_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     clr,
	input  wire logic                     load,
	input  wire bkdr_pkg::key_t           key,
	input  wire logic [bkdr_pkg::PIW-1:0] my_idx,
	input  wire bkdr_pkg::match_t         prev,
	output bkdr_pkg::match_t              next,
	output logic                          live
);
	bkdr_pkg::key_t key_q;
	logic           live_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (clr) begin
			live_q <= 1'b0;
		end else if (load) begin
			live_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q <= key;
		end
	end

	always_comb begin
		next = prev;
		if (!prev.hit && live_q && key_q == key) begin
			next.hit = 1'b1;
			next.idx = my_idx;
		end
	end

	assign live = live_q;
endmodule
`default_nettype wire

>>> rtl/bkdr_file_cell.sv
// One file cell: holds a file id and ORs its match into the chain.
`default_nettype none
module bkdr_file_cell (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire logic [31:0] fid,
	input  wire logic        prev,
	output logic             next
);
	logic [31:0] fid_q;
	logic        live_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (load) begin
			live_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fid_q <= fid;
		end
	end

	assign next = prev | (live_q && fid_q == fid);
endmodule
`default_nettype wire

>>> rtl/block_key_dense_renumber.sv
// Top level of the dense renumber block: cell chains and handshake control.
// Usage:
//   Input channel (valid/ready) carries one word: file_id and block_number.
//   Output channel (valid/ready) carries dense_id, pair_was_new, file_was_new,
//   store_full, pair_total and file_total for each input word.
//   An input word is registered at its accepting edge; when the output register
//   is free, the pair and file cell chains compare it against every held key, a
//   new key is loaded into the next free cell, and the result enters the output
//   register, which raises out_valid. No new word is taken while one is held,
//   since in_ready is low until the cell chains have compared it.
//   While a result waits in the output register, the next word may be taken
//   and is searched as soon as the output register frees up.
//   Reset clears both counts and all cell valid bits; key contents are kept
//   only as valid cells mark them. No clearing pass is needed.
//   A stalled receiver holds the result and stops further searches.
`default_nettype none
module block_key_dense_renumber (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] file_id,
	input  wire logic [31:0] block_number,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       dense_id,
	output logic             pair_was_new,
	output logic             file_was_new,
	output logic             store_full,
	output logic [8:0]       pair_total,
	output logic [6:0]       file_total
);
	localparam int NP = bkdr_pkg::PAIR_SLOTS;
	localparam int NF = bkdr_pkg::FILE_SLOTS;

	bkdr_pkg::key_t               key_q;
	logic                         held_q;
	logic [bkdr_pkg::PCW-1:0]     pcnt_q;
	logic [bkdr_pkg::FCW-1:0]     fcnt_q;
	logic                         ov_q;

	bkdr_pkg::match_t pch [NP+1];
	logic             fch [NF+1];
	logic             plive [NP];
	logic             ins, fins, go, pair_room, file_room;

	assign in_ready = !held_q;
	assign go       = held_q && (!ov_q || out_ready);

	assign pch[0] = '{hit: 1'b0, idx: '0};
	assign fch[0] = 1'b0;

	for (genvar i = 0; i < NP; i++) begin : g_pair
		bkdr_pair_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clr    (1'b0),
			.load   (ins && pcnt_q == bkdr_pkg::PCW'(i)),
			.key    (key_q),
			.my_idx (bkdr_pkg::PIW'(i)),
			.prev   (pch[i]),
			.next   (pch[i+1]),
			.live   (plive[i])
		);
	end

	for (genvar j = 0; j < NF; j++) begin : g_file
		bkdr_file_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (fins && fcnt_q == bkdr_pkg::FCW'(j)),
			.fid    (key_q.fid),
			.prev   (fch[j]),
			.next   (fch[j+1])
		);
	end

	assign pair_room = pcnt_q < bkdr_pkg::PCW'(NP);
	assign file_room = fch[NF] || fcnt_q < bkdr_pkg::FCW'(NF);
	assign ins  = go && !pch[NP].hit && pair_room && file_room;
	assign fins = ins && !fch[NF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			pcnt_q <= '0;
			fcnt_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				held_q <= 1'b1;
			end else if (go) begin
				held_q <= 1'b0;
			end
			if (ins) begin
				pcnt_q <= pcnt_q + 1'b1;
			end
			if (fins) begin
				fcnt_q <= fcnt_q + 1'b1;
			end
			if (go) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_q.fid <= file_id;
			key_q.blk <= block_number;
		end
		if (go) begin
			pair_was_new <= ins;
			file_was_new <= fins;
			store_full   <= !pch[NP].hit && !(pair_room && file_room);
			if (pch[NP].hit) begin
				dense_id <= 8'(pch[NP].idx);
			end else if (ins) begin
				dense_id <= 8'(pcnt_q);
			end else begin
				dense_id <= 8'd0;
			end
			pair_total <= 9'(pcnt_q + bkdr_pkg::PCW'(ins));
			file_total <= 7'(fcnt_q + bkdr_pkg::FCW'(fins));
		end
	end

	assign out_valid = ov_q;

`include "block_key_dense_renumber_macros.svh"
	`BKDR_ASSERT_IMP(a_fins_ins, fins, ins)
	`BKDR_ASSERT_IMP(a_no_ins_full, !held_q, !ins)
	`BKDR_ASSERT_IMP(a_pcnt_max, 1'b1, pcnt_q <= bkdr_pkg::PCW'(NP))
	`BKDR_ASSERT_NEXT(a_cell_live, ins, plive[0])
endmodule
`default_nettype wire

>>> verif/tb_block_key_dense_renumber.sv
// Testbench for the dense renumber block: directed and random accesses checked against a model.
`timescale 1ns / 1ps
`default_nettype none
module tb_block_key_dense_renumber;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] file_id = '0;
	logic [31:0] block_number = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  dense_id;
	logic        pair_was_new;
	logic        file_was_new;
	logic        store_full;
	logic [8:0]  pair_total;
	logic [6:0]  file_total;

	typedef struct packed {
		logic [7:0] id;
		logic       pnew;
		logic       fnew;
		logic       full;
		logic [8:0] ptot;
		logic [6:0] ftot;
	} renum_t;

	bkdr_pkg::key_t seen_pairs[bkdr_pkg::PAIR_SLOTS];
	logic [31:0]    seen_files[bkdr_pkg::FILE_SLOTS];
	int          n_pairs = 0;
	int          n_files = 0;
	renum_t      pending[$];
	int          errors = 0;
	bit          rx_hold = 1'b0;
	int          rx_wait = 0;

	block_key_dense_renumber uut (.*);

	always #4 clk = ~clk;

	function automatic renum_t renumber(input logic [31:0] f, input logic [31:0] b);
		renum_t r;
		bkdr_pkg::key_t k;
		bit fknown;
		r = '0;
		k = '{fid: f, blk: b};
		for (int i = 0; i < n_pairs; i++)
			if (seen_pairs[i] == k) begin
				r.id = i[7:0];
				r.ptot = n_pairs[8:0];
				r.ftot = n_files[6:0];
				return r;
			end
		fknown = 1'b0;
		for (int i = 0; i < n_files; i++)
			if (seen_files[i] == f) fknown = 1'b1;
		if (n_pairs < bkdr_pkg::PAIR_SLOTS && (fknown || n_files < bkdr_pkg::FILE_SLOTS)) begin
			if (!fknown) begin
				seen_files[n_files] = f;
				n_files++;
				r.fnew = 1'b1;
			end
			r.id = n_pairs[7:0];
			seen_pairs[n_pairs] = k;
			n_pairs++;
			r.pnew = 1'b1;
		end else begin
			r.full = 1'b1;
		end
		r.ptot = n_pairs[8:0];
		r.ftot = n_files[6:0];
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("error: %s got %0d want %0d", what, got, want);
		errors++;
	endtask

	task automatic send_word(input logic [31:0] f, input logic [31:0] b);
		repeat ($urandom_range(0, 10)) @(negedge clk);
		file_id = f;
		block_number = b;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		pending.push_back(renumber(f, b));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (rx_hold) out_ready <= 1'b0;
		else if (rx_wait > 0) begin
			out_ready <= 1'b0;
			rx_wait--;
		end else out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		renum_t e;
		if (arst_n && out_valid && out_ready) begin
			rx_wait = $urandom_range(0, 10);
			if (pending.size() == 0) report("unexpected word", 0, 0);
			else begin
				e = pending.pop_front();
				if (dense_id !== e.id) report("dense_id", dense_id, e.id);
				if (pair_was_new !== e.pnew) report("pair_was_new", pair_was_new, e.pnew);
				if (file_was_new !== e.fnew) report("file_was_new", file_was_new, e.fnew);
				if (store_full !== e.full) report("store_full", store_full, e.full);
				if (pair_total !== e.ptot) report("pair_total", pair_total, e.ptot);
				if (file_total !== e.ftot) report("file_total", file_total, e.ftot);
			end
		end
	end

	task automatic test_extremes();
		send_word('0, '0);
		send_word('0, '0);
		send_word('1, '1);
		send_word('0, '1);
		send_word('1, '0);
		send_word(32'hAAAA_AAAA, 32'h5555_5555);
		send_word(32'h5555_5555, 32'hAAAA_AAAA);
		send_word('1, '1);
		send_word(32'h8000_0000, 32'h0000_0001);
		drain();
	endtask

	task automatic test_stalled_receiver();
		rx_hold = 1'b1;
		send_word(32'd7, 32'd1);
		repeat (20) @(negedge clk);
		rx_hold = 1'b0;
		drain();
	endtask

	// small id pools keep hits frequent
	task automatic test_random_mix(input int count);
		logic [31:0] f, b;
		for (int i = 0; i < count; i++) begin
			f = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20);
			b = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
			if ($urandom_range(0, 3) == 0 && n_pairs > 0) begin
				f = seen_pairs[$urandom_range(0, n_pairs - 1)].fid;
				b = seen_pairs[$urandom_range(0, n_pairs - 1)].blk;
			end
			send_word(f, b);
		end
		drain();
	endtask

	task automatic test_file_store_full();
		while (n_files < bkdr_pkg::FILE_SLOTS && n_pairs < bkdr_pkg::PAIR_SLOTS)
			send_word(32'h1000_0000 + n_files, $urandom);
		send_word(32'h2000_0000, 32'd3);
		send_word(seen_files[0], 32'hDEAD_0000 + $urandom_range(0, 99));
		send_word(seen_pairs[0].fid, seen_pairs[0].blk);
		drain();
	endtask

	task automatic test_pair_store_full();
		while (n_pairs < bkdr_pkg::PAIR_SLOTS)
			send_word(seen_files[$urandom_range(0, n_files - 1)], $urandom);
		send_word(seen_files[1], 32'h0BAD_F00D);
		send_word(32'h3000_0000, 32'd0);
		test_random_mix(150);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_extremes();
		test_stalled_receiver();
		test_random_mix(200);
		test_file_store_full();
		test_pair_store_full();
		drain();
		if (errors == 0) $display("block_key_dense_renumber: match");
		else $display("block_key_dense_renumber: mismatch");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("block_key_dense_renumber: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
